FILE: hw/rtl/cmm_pkg.sv
// ----------------------------------------------------------------------------
// cmm_pkg
// Shared types and constants for the coprocessor mailbox management block.
// ----------------------------------------------------------------------------
package cmm_pkg;

    localparam int unsigned WORD_W   = 64;
    localparam int unsigned EP_W     = 8;
    localparam int unsigned CODE_W   = 16;
    localparam int unsigned CFG_IX_W = 3;
    localparam int unsigned SYS_EPS  = 4;

    // input kinds
    typedef enum logic [2:0] {
        KIND_RX     = 3'd0,
        KIND_SET_AP = 3'd1,
        KIND_START  = 3'd2,
        KIND_SEND   = 3'd3,
        KIND_WAKE   = 3'd4
    } in_kind_t;

    typedef enum logic [1:0] {
        OUT_STATUS   = 2'd0,
        OUT_TRANSMIT = 2'd1,
        OUT_DELIVER  = 2'd2
    } out_kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_UNHANDLED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CFG_MIN_VERSION    = 3'd0,
        CFG_MAX_VERSION    = 3'd1,
        CFG_POWER_ON       = 3'd2,
        CFG_POWER_SLEEP    = 3'd3,
        CFG_POWER_QUIESCED = 3'd4
    } cfg_index_t;

    // management message types, carried in bits 59..52
    localparam logic [7:0] MT_HELLO       = 8'd1;
    localparam logic [7:0] MT_HELLO_ACK   = 8'd2;
    localparam logic [7:0] MT_STARTEP     = 8'd5;
    localparam logic [7:0] MT_IOP_PWR     = 8'd6;
    localparam logic [7:0] MT_IOP_PWR_ACK = 8'd7;
    localparam logic [7:0] MT_EPMAP       = 8'd8;
    localparam logic [7:0] MT_AP_PWR      = 8'd11;

    localparam int unsigned TYPE_SHIFT = 52;
    localparam int unsigned EPMAP_LAST_BIT = 51;

    localparam logic [CODE_W-1:0] RST_MIN_VERSION    = 16'd11;
    localparam logic [CODE_W-1:0] RST_MAX_VERSION    = 16'd12;
    localparam logic [CODE_W-1:0] RST_POWER_ON       = 16'd32;
    localparam logic [CODE_W-1:0] RST_POWER_SLEEP    = 16'd1;
    localparam logic [CODE_W-1:0] RST_POWER_QUIESCED = 16'd16;

    typedef struct packed {
        logic [CODE_W-1:0] min_version;
        logic [CODE_W-1:0] max_version;
        logic [CODE_W-1:0] power_on_code;
    } cmm_cfg_t;

    // everything the output side needs to play out one input word
    typedef struct packed {
        out_kind_t          out_kind;
        logic [EP_W-1:0]    ep;
        logic [WORD_W-1:0]  word;
        status_t            status;
        logic [CODE_W-1:0]  iop_power;
        logic [CODE_W-1:0]  ap_power;
        logic [SYS_EPS-1:0] start_mask;
    } cmm_bundle_t;

    function automatic logic [WORD_W-1:0] mgmt_word(input logic [7:0] mtype,
                                                    input logic [51:0] data);
        return {4'd0, mtype, data};
    endfunction

    function automatic logic [WORD_W-1:0] start_word(input logic [EP_W-1:0] ep);
        return mgmt_word(MT_STARTEP, {12'd0, ep, 32'd2});
    endfunction

endpackage

FILE: hw/rtl/cmm_core.sv
// ----------------------------------------------------------------------------
// cmm_core
// Input register, tracked state and the single-pass decode of one word.
// ----------------------------------------------------------------------------
module cmm_core
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmm_pkg::cmm_cfg_t         cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [2:0]                kind,
    input  logic [cmm_pkg::WORD_W-1:0] msg_word,
    input  logic [cmm_pkg::EP_W-1:0]   endpoint,
    input  logic [cmm_pkg::CODE_W-1:0] power_request,
    output logic                      bundle_valid,
    input  logic                      bundle_ready,
    output cmm_pkg::cmm_bundle_t      bundle
);

    logic                       valid_reg;
    logic [2:0]                 kind_reg;
    logic [cmm_pkg::WORD_W-1:0] word_reg;
    logic [cmm_pkg::EP_W-1:0]   ep_reg;
    logic [cmm_pkg::CODE_W-1:0] preq_reg;

    logic [cmm_pkg::CODE_W-1:0] iop_reg, iop_next;
    logic [cmm_pkg::CODE_W-1:0] ap_reg, ap_next;
    logic [63:0]                map_reg, map_next;
    logic [31:0]                client_reg, client_next;

    logic        advance;
    logic [7:0]  mtype;
    logic [15:0] ver_lo, ver_hi, ver;
    logic [2:0]  map_base;

    assign advance      = valid_reg && bundle_ready;
    assign in_ready     = !valid_reg || bundle_ready;
    assign bundle_valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            kind_reg <= kind;
            word_reg <= msg_word;
            ep_reg   <= endpoint;
            preq_reg <= power_request;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iop_reg    <= cmm_pkg::RST_POWER_SLEEP;
            ap_reg     <= cmm_pkg::RST_POWER_QUIESCED;
            map_reg    <= '0;
            client_reg <= '0;
        end
        else if (advance)
        begin
            iop_reg    <= iop_next;
            ap_reg     <= ap_next;
            map_reg    <= map_next;
            client_reg <= client_next;
        end
    end

    assign mtype    = word_reg[59:52];
    assign ver_lo   = word_reg[15:0];
    assign ver_hi   = word_reg[31:16];
    assign ver      = (ver_hi < cfg.max_version) ? ver_hi : cfg.max_version;
    assign map_base = word_reg[34:32];

    always_comb
    begin
        iop_next    = iop_reg;
        ap_next     = ap_reg;
        map_next    = map_reg;
        client_next = client_reg;

        bundle.out_kind   = cmm_pkg::OUT_STATUS;
        bundle.ep         = '0;
        bundle.word       = '0;
        bundle.status     = cmm_pkg::ST_OK;
        bundle.start_mask = '0;

        unique case (kind_reg)
            cmm_pkg::KIND_RX:
            begin
                if (ep_reg == '0)
                begin
                    case (mtype)
                        cmm_pkg::MT_HELLO:
                        begin
                            if (ver_lo > cfg.max_version || ver_hi < cfg.min_version)
                            begin
                                bundle.status = cmm_pkg::ST_INVALID;
                            end
                            else
                            begin
                                bundle.out_kind = cmm_pkg::OUT_TRANSMIT;
                                bundle.word = cmm_pkg::mgmt_word(cmm_pkg::MT_HELLO_ACK,
                                                                 {20'd0, ver, ver});
                            end
                        end
                        cmm_pkg::MT_IOP_PWR_ACK:
                        begin
                            iop_next = word_reg[15:0];
                        end
                        cmm_pkg::MT_AP_PWR:
                        begin
                            ap_next = word_reg[15:0];
                        end
                        cmm_pkg::MT_EPMAP:
                        begin
                            // bases of 2 and up shift everything past bit 63
                            if (map_base == 3'd0)
                            begin
                                map_next = map_reg | {32'd0, word_reg[31:0]};
                            end
                            else if (map_base == 3'd1)
                            begin
                                map_next = map_reg | {word_reg[31:0], 32'd0};
                            end
                            bundle.out_kind = cmm_pkg::OUT_TRANSMIT;
                            bundle.word = cmm_pkg::mgmt_word(cmm_pkg::MT_EPMAP,
                                {17'd0, map_base, 32'd0});
                            if (word_reg[cmm_pkg::EPMAP_LAST_BIT])
                            begin
                                bundle.word[cmm_pkg::EPMAP_LAST_BIT] = 1'b1;
                                bundle.start_mask = map_next[cmm_pkg::SYS_EPS:1];
                            end
                            else
                            begin
                                bundle.word[0] = 1'b1;
                            end
                        end
                        default:
                        begin
                            bundle.status = cmm_pkg::ST_UNHANDLED;
                        end
                    endcase
                end
                else if (ep_reg == 8'd1 || ep_reg == 8'd2 || ep_reg == 8'd4)
                begin
                    bundle.status = cmm_pkg::ST_OK;
                end
                else if (ep_reg[7:5] == 3'b001 && client_reg[ep_reg[4:0]])
                begin
                    bundle.out_kind = cmm_pkg::OUT_DELIVER;
                    bundle.ep       = ep_reg;
                    bundle.word     = word_reg;
                end
                else
                begin
                    bundle.status = cmm_pkg::ST_UNHANDLED;
                end
            end
            cmm_pkg::KIND_SET_AP:
            begin
                if (ap_reg != preq_reg)
                begin
                    bundle.out_kind = cmm_pkg::OUT_TRANSMIT;
                    bundle.word = cmm_pkg::mgmt_word(cmm_pkg::MT_AP_PWR, {36'd0, preq_reg});
                end
            end
            cmm_pkg::KIND_START:
            begin
                // client endpoints live at 32..63
                if (ep_reg[7:5] != 3'b001 || !map_reg[{1'b1, ep_reg[4:0]}])
                begin
                    bundle.status = cmm_pkg::ST_INVALID;
                end
                else
                begin
                    client_next[ep_reg[4:0]] = 1'b1;
                    bundle.out_kind = cmm_pkg::OUT_TRANSMIT;
                    bundle.word     = cmm_pkg::start_word(ep_reg);
                end
            end
            cmm_pkg::KIND_SEND:
            begin
                bundle.out_kind = cmm_pkg::OUT_TRANSMIT;
                bundle.ep       = ep_reg;
                bundle.word     = word_reg;
            end
            cmm_pkg::KIND_WAKE:
            begin
                bundle.out_kind = cmm_pkg::OUT_TRANSMIT;
                bundle.word = cmm_pkg::mgmt_word(cmm_pkg::MT_IOP_PWR,
                                                 {36'd0, cfg.power_on_code});
            end
            default:
            begin
                bundle.status = cmm_pkg::ST_UNHANDLED;
            end
        endcase

        bundle.iop_power = iop_next;
        bundle.ap_power  = ap_next;
    end

endmodule

FILE: hw/rtl/cmm_emit.sv
// ----------------------------------------------------------------------------
// cmm_emit
// Result register; plays out the first result and any system endpoint starts.
// ----------------------------------------------------------------------------
module cmm_emit
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      bundle_valid,
    output logic                      bundle_ready,
    input  cmm_pkg::cmm_bundle_t      bundle,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [1:0]                out_kind,
    output logic [cmm_pkg::EP_W-1:0]   out_endpoint,
    output logic [cmm_pkg::WORD_W-1:0] out_word,
    output logic [1:0]                status,
    output logic [cmm_pkg::CODE_W-1:0] iop_power_now,
    output logic [cmm_pkg::CODE_W-1:0] ap_power_now,
    output logic                      last
);

    logic                        valid_reg;
    logic                        first_reg;
    logic [cmm_pkg::SYS_EPS-1:0] mask_reg, mask_next;
    cmm_pkg::cmm_bundle_t        hold_reg;

    logic [cmm_pkg::SYS_EPS-1:0] low_bit;
    logic [cmm_pkg::EP_W-1:0]    start_ep;
    logic                        take;

    assign low_bit = mask_reg & (~mask_reg + 1'b1);

    always_comb
    begin
        start_ep = 8'd4;
        if (mask_reg[0])
        begin
            start_ep = 8'd1;
        end
        else if (mask_reg[1])
        begin
            start_ep = 8'd2;
        end
        else if (mask_reg[2])
        begin
            start_ep = 8'd3;
        end
    end

    assign last = first_reg ? (mask_reg == '0) : (mask_reg == low_bit);
    assign out_valid    = valid_reg;
    assign bundle_ready = !valid_reg || (out_ready && last);
    assign take         = bundle_valid && bundle_ready;
    assign mask_next    = first_reg ? mask_reg : (mask_reg & ~low_bit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            first_reg <= 1'b0;
            mask_reg  <= '0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
            first_reg <= 1'b1;
            mask_reg  <= bundle.start_mask;
        end
        else if (valid_reg && out_ready)
        begin
            valid_reg <= !last;
            first_reg <= 1'b0;
            mask_reg  <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_reg <= bundle;
        end
    end

    always_comb
    begin
        if (first_reg)
        begin
            out_kind     = hold_reg.out_kind;
            out_endpoint = hold_reg.ep;
            out_word     = hold_reg.word;
            status       = hold_reg.status;
        end
        else
        begin
            out_kind     = cmm_pkg::OUT_TRANSMIT;
            out_endpoint = '0;
            out_word     = cmm_pkg::start_word(start_ep);
            status       = cmm_pkg::ST_OK;
        end
    end

    assign iop_power_now = hold_reg.iop_power;
    assign ap_power_now  = hold_reg.ap_power;

`ifndef SYNTHESIS
    a_pending_work: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (first_reg || mask_reg != '0))
        else $error("result register valid with nothing left to send");

    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && out_ready && !last && !take) |=> valid_reg)
        else $error("word sequence dropped before its last result");

    a_start_is_tx: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !first_reg) |-> (out_kind == cmm_pkg::OUT_TRANSMIT
                                       && status == cmm_pkg::ST_OK))
        else $error("endpoint start result is not a transmit");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && out_ready && last && !bundle_valid) |=> !valid_reg)
        else $error("result register still valid after last word");
`endif

endmodule

FILE: hw/rtl/coprocessor_mailbox_mgmt.sv
// ----------------------------------------------------------------------------
// coprocessor_mailbox_mgmt
// Host side of a coprocessor mailbox management protocol.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one word per handshake, either a word
// received from the mailbox (kind 0) or a host request: set AP power, start a
// client endpoint, send to an endpoint, wake the IOP.
// Output channel (out_valid/out_ready): one to five result words per input,
// the final one flagged by last. Each carries the tracked IOP and AP power
// states as they stand after that input.
// The first result of an accepted word passes through the input register and
// then the result register before it is offered on the output. The
// input register and the result register each take a new word whenever they
// empty, so single-result words flow at one per cycle while out_ready stays
// high; an endpoint-map word that starts n system endpoints occupies the result
// register until its last start result is taken.
// Stalls: if out_ready is low the result holds, one more word waits in the
// input register, then in_ready drops.
// Reset: power states return to the sleep and quiesced reset codes, endpoint
// map and client registrations clear, configuration returns to its defaults.
// The user must write configuration (cfg_we/cfg_index/cfg_data) only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module coprocessor_mailbox_mgmt
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [cmm_pkg::CFG_IX_W-1:0] cfg_index,
    input  logic [cmm_pkg::CODE_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [2:0]                kind,
    input  logic [cmm_pkg::WORD_W-1:0] msg_word,
    input  logic [cmm_pkg::EP_W-1:0]   endpoint,
    input  logic [cmm_pkg::CODE_W-1:0] power_request,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [1:0]                out_kind,
    output logic [cmm_pkg::EP_W-1:0]   out_endpoint,
    output logic [cmm_pkg::WORD_W-1:0] out_word,
    output logic [1:0]                status,
    output logic [cmm_pkg::CODE_W-1:0] iop_power_now,
    output logic [cmm_pkg::CODE_W-1:0] ap_power_now,
    output logic                      last
);

    cmm_pkg::cmm_cfg_t          cfg_reg;

    logic                 bundle_valid;
    logic                 bundle_ready;
    cmm_pkg::cmm_bundle_t bundle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_version   <= cmm_pkg::RST_MIN_VERSION;
            cfg_reg.max_version   <= cmm_pkg::RST_MAX_VERSION;
            cfg_reg.power_on_code <= cmm_pkg::RST_POWER_ON;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cmm_pkg::CFG_MIN_VERSION:    cfg_reg.min_version   <= cfg_data;
                cmm_pkg::CFG_MAX_VERSION:    cfg_reg.max_version   <= cfg_data;
                cmm_pkg::CFG_POWER_ON:       cfg_reg.power_on_code <= cfg_data;
                // sleep and quiesced codes only seed the power states, and reset
                // brings them back to their defaults, so nothing is kept for them
                default:
                begin
                end
            endcase
        end
    end

    cmm_core u_core
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg                 (cfg_reg),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .kind                (kind),
        .msg_word            (msg_word),
        .endpoint            (endpoint),
        .power_request       (power_request),
        .bundle_valid        (bundle_valid),
        .bundle_ready        (bundle_ready),
        .bundle              (bundle)
    );

    cmm_emit u_emit
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .bundle_valid  (bundle_valid),
        .bundle_ready  (bundle_ready),
        .bundle        (bundle),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_kind      (out_kind),
        .out_endpoint  (out_endpoint),
        .out_word      (out_word),
        .status        (status),
        .iop_power_now (iop_power_now),
        .ap_power_now  (ap_power_now),
        .last          (last)
    );

endmodule
